// ----- sv/wpts_pkg.sv -----
`default_nettype none
package wpts_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_WIDTH = 32;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;

    // divider geometry: numerator magnitude, denominator, partial remainder
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 34;
    localparam int REM_W   = DEN_W + 1;
    localparam int DIV_LAT = NUM_W + 1;

    localparam int NEAR_W = 31;
    localparam int HALF_W = 31;
    localparam int PX_W   = 14;
    localparam int CFG_W  = 31;
    localparam int CFG_IDX_W = 2;
    localparam int COEF_IDX_W = 4;
    localparam int MAT_N = 16;

    localparam logic [NEAR_W-1:0] NEAR_RST = NEAR_W'(64'd1 << FRAC_BITS);
    localparam logic [HALF_W-1:0] HALF_RST = HALF_W'(64'd1 << FRAC_BITS);
    localparam logic [PX_W-1:0]   WPX_RST  = PX_W'(1024);
    localparam logic [PX_W-1:0]   HPX_RST  = PX_W'(768);

    localparam logic signed [NUM_W-1:0] ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam logic signed [NUM_W-1:0] ACC_MIN = -ACC_MAX - 64'sd1;
    localparam logic signed [NUM_W-1:0] DATA_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam logic signed [NUM_W-1:0] DATA_MIN = -DATA_MAX - 64'sd1;

    localparam logic signed [NUM_W-1:0] SENT_FULL = -(64'sd100000 <<< FRAC_BITS);
    localparam logic signed [DATA_W-1:0] SENTINEL_PX =
        (SENT_FULL < DATA_MIN) ? DATA_MIN[DATA_W-1:0] : SENT_FULL[DATA_W-1:0];

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_PROJECT = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR = 2'd0,
        REG_HALF = 2'd1,
        REG_WPX  = 2'd2,
        REG_HPX  = 2'd3
    } t_reg_idx;

    // sideband that rides alongside the dividers
    typedef struct packed {
        logic vld;
        logic vis;
        logic fault;
    } t_side;

    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [NUM_W-1:0] x);
        logic signed [NUM_W-1:0] y;
        if (x > ACC_MAX) begin
            y = ACC_MAX;
        end else if (x < ACC_MIN) begin
            y = ACC_MIN;
        end else begin
            y = x;
        end
        return y[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/wpts_div.sv -----
`default_nettype none
module wpts_div
    import wpts_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [NUM_W-1:0]  i_num,
    input  wire logic signed [DEN_W-1:0]  i_den,
    output logic signed [DATA_W-1:0]      o_quo,
    output logic                          o_zero
);

    localparam logic [NUM_W-1:0] QPOS_MAX = NUM_W'(DATA_MAX);
    localparam logic [NUM_W-1:0] QNEG_MAX = QPOS_MAX + NUM_W'(1);

    logic [REM_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_d   [NUM_W];
    logic             r_neg [NUM_W];
    logic             r_sn  [NUM_W];
    logic             r_dz  [NUM_W];
    logic             r_nz  [NUM_W];

    logic [NUM_W-1:0] w_nmag;
    logic [DEN_W-1:0] w_dmag;
    logic [NUM_W-1:0] w_q;
    logic signed [DATA_W-1:0] n_quo;

    assign w_nmag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_dmag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    // one restoring step per stage
    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [REM_W-1:0] w_rin;
        logic [NUM_W-1:0] w_nin;
        logic [DEN_W-1:0] w_din;
        logic             w_neg, w_sn, w_dz, w_nz;
        logic [REM_W-1:0] w_sh;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rin = '0;
            assign w_nin = w_nmag;
            assign w_din = w_dmag;
            assign w_neg = i_num[NUM_W-1] ^ i_den[DEN_W-1];
            assign w_sn  = i_num[NUM_W-1];
            assign w_dz  = (i_den == '0);
            assign w_nz  = (i_num == '0);
        end else begin : g_next
            assign w_rin = r_rem[k-1];
            assign w_nin = r_nq[k-1];
            assign w_din = r_d[k-1];
            assign w_neg = r_neg[k-1];
            assign w_sn  = r_sn[k-1];
            assign w_dz  = r_dz[k-1];
            assign w_nz  = r_nz[k-1];
        end

        assign w_sh    = {w_rin[REM_W-2:0], w_nin[NUM_W-1]};
        assign w_trial = w_sh - {1'b0, w_din};
        assign w_ge    = ~w_trial[REM_W-1];

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? w_trial : w_sh;
            r_nq[k]  <= {w_nin[NUM_W-2:0], w_ge};
            r_d[k]   <= w_din;
            r_neg[k] <= w_neg;
            r_sn[k]  <= w_sn;
            r_dz[k]  <= w_dz;
            r_nz[k]  <= w_nz;
        end
    end

    assign w_q = r_nq[NUM_W-1];

    // sign fix and saturation; zero divisor saturates toward the numerator sign, 0/0 gives 0
    always_comb begin
        if (r_dz[NUM_W-1]) begin
            if (r_nz[NUM_W-1]) begin
                n_quo = '0;
            end else if (r_sn[NUM_W-1]) begin
                n_quo = DATA_MIN[DATA_W-1:0];
            end else begin
                n_quo = DATA_MAX[DATA_W-1:0];
            end
        end else if (r_neg[NUM_W-1]) begin
            n_quo = (w_q > QNEG_MAX) ? DATA_MIN[DATA_W-1:0] : DATA_W'(-w_q[DATA_W-1:0]);
        end else begin
            n_quo = (w_q > QPOS_MAX) ? DATA_MAX[DATA_W-1:0] : w_q[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_quo  <= n_quo;
        o_zero <= r_dz[NUM_W-1];
    end

endmodule
`default_nettype wire

// ----- sv/world_point_to_screen_projector.sv -----
`default_nettype none
// world point to screen projector. start with cmd load writes one coefficient of the
// 4x4 row-major transform (cleared to zero by reset) and returns nothing; start with
// cmd project takes one point and returns one word on o_valid. busy is always low:
// a new command is taken on every cycle, and each point passes through three chained
// 65-stage pipelined dividers (one quotient bit per restoring stage) plus the
// arithmetic register stages between and around them. the receiver
// cannot stall, so results must be captured in the strobe cycle. a coefficient load
// is seen by every point accepted after it. configuration registers are read live
// and must be written only while no point is in flight.
module world_point_to_screen_projector
    import wpts_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_cmd,
    input  wire logic [COEF_IDX_W-1:0]       i_coef_index,
    input  wire logic signed [DATA_W-1:0]    i_coef_value,
    input  wire logic signed [DATA_W-1:0]    i_point_x,
    input  wire logic signed [DATA_W-1:0]    i_point_y,
    input  wire logic signed [DATA_W-1:0]    i_point_z,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]            i_cfg_data,
    output logic                             o_valid,
    output logic signed [DATA_W-1:0]         o_screen_x,
    output logic signed [DATA_W-1:0]         o_screen_y,
    output logic                             o_visible,
    output logic                             o_divide_fault
);

    // configuration
    logic [NEAR_W-1:0] r_near;
    logic [HALF_W-1:0] r_half;
    logic [PX_W-1:0]   r_wpx;
    logic [PX_W-1:0]   r_hpx;

    // transform store
    logic signed [DATA_W-1:0] r_mat [MAT_N];

    // stage 0: captured point
    logic                     r_v0;
    logic signed [DATA_W-1:0] r_p [3];

    // stage 1: products and w terms
    logic                     r_v1;
    logic signed [NUM_W-1:0]  r_prod [12];
    logic signed [DATA_W-1:0] r_wt [4];

    // stage 2: homogeneous coordinates
    logic                     r_v2;
    logic signed [DATA_W-1:0] r_h [4];
    logic signed [NUM_W-1:0]  w_acc [4];

    // divider a: divide by w
    logic                     r_va [DIV_LAT];
    logic signed [DATA_W-1:0] w_qa [3];
    logic                     w_za [3];

    // stage 3: near plane numerators, half height numerator
    t_side                    r_s3;
    logic signed [NUM_W-1:0]  r_nx3, r_ny3, r_nh3;
    logic signed [DEN_W-1:0]  r_dz3, r_dh3;
    logic signed [DATA_W-1:0] w_rx, w_ry, w_rz;

    // divider b
    t_side                    r_sb [DIV_LAT];
    logic signed [DATA_W-1:0] w_qb [3];
    logic                     w_zb [3];

    // stage 4: frame mapping numerators
    t_side                    r_s4;
    logic signed [NUM_W-1:0]  r_nx4, r_ny4;
    logic signed [DEN_W-1:0]  r_dx4, r_dy4;
    logic signed [DATA_W-1:0] w_xn, w_yn, w_hy;
    logic signed [DATA_W+1:0] w_ax, w_ay;
    logic signed [DATA_W+PX_W+2:0] w_px, w_py;

    // divider c
    t_side                    r_sc [DIV_LAT];
    logic signed [DATA_W-1:0] w_qc [2];
    logic                     w_zc [2];

    // output word
    logic                     r_valid;
    logic signed [DATA_W-1:0] r_screen_x, r_screen_y;
    logic                     r_visible, r_fault;

    logic w_take;

    assign busy   = 1'b0;
    assign w_take = start & ~busy;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RST;
            r_half <= HALF_RST;
            r_wpx  <= WPX_RST;
            r_hpx  <= HPX_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_NEAR: r_near <= i_cfg_data[NEAR_W-1:0];
                REG_HALF: r_half <= i_cfg_data[HALF_W-1:0];
                REG_WPX:  r_wpx  <= i_cfg_data[PX_W-1:0];
                REG_HPX:  r_hpx  <= i_cfg_data[PX_W-1:0];
                default:  r_near <= r_near;
            endcase
        end
    end

    // coefficient loads land at the accepting edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAT_N; i++) begin
                r_mat[i] <= '0;
            end
        end else if (w_take && t_cmd'(i_cmd) == CMD_LOAD) begin
            r_mat[i_coef_index] <= i_coef_value;
        end
    end

    // valid bits for the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= w_take && t_cmd'(i_cmd) == CMD_PROJECT;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= i_point_x;
        r_p[1] <= i_point_y;
        r_p[2] <= i_point_z;
    end

    // matrix products, w column captured with them so later loads cannot leak in
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[r*3+j] <= r_mat[r*4+j] * r_p[j];
            end
            r_wt[r] <= r_mat[r*4+3];
        end
    end

    // row sums, each product floored to q
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_acc[r] = NUM_W'(r_wt[r]) + (r_prod[r*3] >>> FRAC_BITS)
                     + (r_prod[r*3+1] >>> FRAC_BITS) + (r_prod[r*3+2] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            r_h[r] <= sat_acc(w_acc[r]);
        end
    end

    // ray = row / w
    for (genvar i = 0; i < 3; i++) begin : g_diva
        wpts_div u_div (
            .i_clk  (i_clk),
            .i_num  (NUM_W'(r_h[i]) <<< FRAC_BITS),
            .i_den  (DEN_W'(r_h[3])),
            .o_quo  (w_qa[i]),
            .o_zero (w_za[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_va[i] <= 1'b0;
            end
        end else begin
            r_va[0] <= r_v2;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_va[i] <= r_va[i-1];
            end
        end
    end

    assign w_rx = sat_acc(NUM_W'(w_qa[0]));
    assign w_ry = sat_acc(NUM_W'(w_qa[1]));
    assign w_rz = sat_acc(NUM_W'(w_qa[2]));

    // visibility decided here; z of zero is a fault as well
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3.vld   <= r_va[DIV_LAT-1];
            r_s3.vis   <= w_rz < 0;
            r_s3.fault <= w_za[0] | w_za[1] | w_za[2] | (w_rz == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx3 <= w_rx * $signed(DATA_W'(r_near));
        r_ny3 <= w_ry * $signed(DATA_W'(r_near));
        r_dz3 <= -DEN_W'(w_rz);
        r_nh3 <= $signed(NUM_W'(r_half) * NUM_W'(r_hpx));
        r_dh3 <= $signed(DEN_W'(r_wpx));
    end

    // near plane x and y, half height of the window
    wpts_div u_div_xn (
        .i_clk  (i_clk),
        .i_num  (r_nx3),
        .i_den  (r_dz3),
        .o_quo  (w_qb[0]),
        .o_zero (w_zb[0])
    );

    wpts_div u_div_yn (
        .i_clk  (i_clk),
        .i_num  (r_ny3),
        .i_den  (r_dz3),
        .o_quo  (w_qb[1]),
        .o_zero (w_zb[1])
    );

    wpts_div u_div_hy (
        .i_clk  (i_clk),
        .i_num  (r_nh3),
        .i_den  (r_dh3),
        .o_quo  (w_qb[2]),
        .o_zero (w_zb[2])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_sb[i] <= '0;
            end
        end else begin
            r_sb[0] <= r_s3;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    assign w_xn = sat_acc(NUM_W'(w_qb[0]));
    assign w_yn = sat_acc(NUM_W'(w_qb[1]));
    assign w_hy = sat_acc(NUM_W'(w_qb[2]));

    // window offset, v flipped, then times frame size
    assign w_ax = (DATA_W+2)'(w_xn) + $signed((DATA_W+2)'(r_half));
    assign w_ay = (DATA_W+2)'(w_hy) - (DATA_W+2)'(w_yn);
    assign w_px = w_ax * $signed((PX_W+1)'(r_wpx));
    assign w_py = w_ay * $signed((PX_W+1)'(r_hpx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4 <= '0;
        end else begin
            r_s4.vld   <= r_sb[DIV_LAT-1].vld;
            r_s4.vis   <= r_sb[DIV_LAT-1].vis;
            // divides past the visibility test only count for visible points
            r_s4.fault <= r_sb[DIV_LAT-1].fault
                        | (r_sb[DIV_LAT-1].vis & (w_zb[0] | w_zb[1] | w_zb[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx4 <= NUM_W'(w_px);
        r_ny4 <= NUM_W'(w_py);
        r_dx4 <= $signed(DEN_W'(r_half)) <<< 1;
        r_dy4 <= DEN_W'(w_hy) <<< 1;
    end

    // scale to pixels
    wpts_div u_div_sx (
        .i_clk  (i_clk),
        .i_num  (r_nx4),
        .i_den  (r_dx4),
        .o_quo  (w_qc[0]),
        .o_zero (w_zc[0])
    );

    wpts_div u_div_sy (
        .i_clk  (i_clk),
        .i_num  (r_ny4),
        .i_den  (r_dy4),
        .o_quo  (w_qc[1]),
        .o_zero (w_zc[1])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_sc[i] <= '0;
            end
        end else begin
            r_sc[0] <= r_s4;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sc[i] <= r_sc[i-1];
            end
        end
    end

    // output word, sentinel coordinates for points behind the eye
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_sc[DIV_LAT-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_visible  <= r_sc[DIV_LAT-1].vis;
        r_screen_x <= r_sc[DIV_LAT-1].vis ? w_qc[0] : SENTINEL_PX;
        r_screen_y <= r_sc[DIV_LAT-1].vis ? w_qc[1] : SENTINEL_PX;
        r_fault    <= r_sc[DIV_LAT-1].fault
                    | (r_sc[DIV_LAT-1].vis & (w_zc[0] | w_zc[1]));
    end

    assign o_valid        = r_valid;
    assign o_screen_x     = r_screen_x;
    assign o_screen_y     = r_screen_y;
    assign o_visible      = r_visible;
    assign o_divide_fault = r_fault;

endmodule
`default_nettype wire
